// ----- design/timed_digital_output_bank_defines.svh -----
// Assertion macros shared by the timed digital output bank RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef TIMED_DIGITAL_OUTPUT_BANK_DEFINES_SVH
`define TIMED_DIGITAL_OUTPUT_BANK_DEFINES_SVH

// The property must hold at every sampled clock edge outside reset.
`define TDOB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The antecedent must imply the consequent in the following cycle.
`define TDOB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tdob_pkg.sv -----
`timescale 1ns / 1ps
// Package for the timed digital output bank: field widths, codes and the cell status type.
// Used by tdob_cell and timed_digital_output_bank; depends on nothing.
package tdob_pkg;

  // Field widths of the input and result items.
  localparam int unsigned IDX_W = 3;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned LVL_W = 8;

  // Number of outputs an index can address.
  localparam int unsigned IDX_SPAN = 8;

  // Default bank size.
  localparam int unsigned NUM_OUTPUTS_DEF = 8;

  // Function codes of an input item.
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Cause codes of a result item.
  localparam logic CAUSE_SET    = 1'b0;
  localparam logic CAUSE_EXPIRY = 1'b1;

  // Status one cell reports to the bank controller.
  typedef struct packed {
    logic tok;   // cell holds the walk token
    logic fire;  // cell holds the token and its countdown expires on this step
    logic last;  // no later cell expires during this walk
  } cell_st_t;

endpackage

// ----- design/tdob_cell.sv -----
`timescale 1ns / 1ps
// One output cell: level bit, 16-bit countdown and its slot of the tick token chain.
// Depends on tdob_pkg.
module tdob_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        tok_i,
  input  logic                        set_en_i,
  input  logic                        level_i,
  input  logic [tdob_pkg::CNT_W-1:0]  count_i,
  input  logic                        later_i,
  output logic                        tok_o,
  output logic                        level_o,
  output logic                        later_o,
  output tdob_pkg::cell_st_t          st_o
);
  import tdob_pkg::*;

  logic             tok_q;
  logic             level_q;
  logic [CNT_W-1:0] cnt_q;
  logic             step;
  logic             expiring;

  // The cell is walked when it holds the token and the output side can take a result.
  assign step     = tok_q && adv_i;
  assign expiring = (cnt_q == CNT_W'(1));

  // A set transfer loads the cell; a tick step counts down and inverts on expiry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      level_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (tok_i) begin
        tok_q <= 1'b1;
      end else if (step) begin
        tok_q <= 1'b0;
      end
      if (set_en_i) begin
        level_q <= level_i;
        cnt_q   <= count_i;
      end else if (step && (cnt_q != '0)) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (expiring) begin
          level_q <= ~level_q;
        end
      end
    end
  end

  // Token hand-off and the chain that tells earlier cells a later one will fire.
  assign tok_o   = step;
  assign level_o = level_q;
  assign later_o = later_i || expiring;

  always_comb begin
    st_o.tok  = tok_q;
    st_o.fire = tok_q && expiring;
    st_o.last = !later_i;
  end

endmodule

// ----- design/timed_digital_output_bank.sv -----
`timescale 1ns / 1ps
// Top level of the timed digital output bank: a chain of output cells and the result register.
// Depends on tdob_pkg, tdob_cell and timed_digital_output_bank_defines.svh.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+------------------------------------------------
//  input   | in_valid_i / in_stall_o | func_i, output_index_i, level_i, countdown_i
//  result  | out_valid_o/out_stall_i | levels_o, changed_index_o, cause_o, last_o
//
// A set transfer loads its result straight into the output register.
// A tick passes a token down the cell chain, one cell per cycle while out_stall_i does not
// hold the result register: the walk visits all NUM_OUTPUTS cells after the tick transfer,
// and the next transfer is taken only once the walk has ended.
// The input stalls for the whole tick walk and while a held result blocks the register.
// Reset clears all levels, countdowns, the token and the result valid flag.
module timed_digital_output_bank #(
  parameter int unsigned NUM_OUTPUTS = tdob_pkg::NUM_OUTPUTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [tdob_pkg::IDX_W-1:0]  output_index_i,
  input  logic                        level_i,
  input  logic [tdob_pkg::CNT_W-1:0]  countdown_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tdob_pkg::LVL_W-1:0]  levels_o,
  output logic [tdob_pkg::IDX_W-1:0]  changed_index_o,
  output logic                        cause_o,
  output logic                        last_o
);
  import tdob_pkg::*;

  `include "timed_digital_output_bank_defines.svh"

  localparam int unsigned PTR_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_OUTPUTS - 1);
  localparam int unsigned LVL_CELLS = (NUM_OUTPUTS < LVL_W) ? NUM_OUTPUTS : LVL_W;

  logic                   busy_q;
  logic [PTR_W-1:0]       ptr_q;
  logic                   out_valid_q;
  logic [LVL_W-1:0]       levels_q;
  logic [IDX_W-1:0]       changed_index_q;
  logic                   cause_q;
  logic                   last_q;

  logic                   adv;
  logic                   in_acc;
  logic                   start;
  logic                   set_acc;
  logic                   fire;
  logic                   fire_last;
  logic [NUM_OUTPUTS-1:0] set_en_vec;
  logic [NUM_OUTPUTS-1:0] tok_vec;
  logic [NUM_OUTPUTS-1:0] tok_out_vec;
  logic [NUM_OUTPUTS-1:0] lvl_vec;
  logic [NUM_OUTPUTS-1:0] later_vec;
  logic [NUM_OUTPUTS-1:0] fire_vec;
  logic [NUM_OUTPUTS-1:0] last_vec;
  logic [LVL_W-1:0]       levels_w;
  logic [LVL_W-1:0]       fire_w;
  logic [LVL_W-1:0]       set_mask;
  logic [LVL_W-1:0]       set_levels;
  cell_st_t               cell_st [NUM_OUTPUTS];

  // Handshake: the walk and a held result both block new input.
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = busy_q || !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && (func_i == FUNC_TICK);
  assign set_acc    = in_acc && (func_i == FUNC_SET)
                      && (32'(output_index_i) < 32'(NUM_OUTPUTS));

  // The row of cells with the token chain running up and the expiry look-ahead running down.
  for (genvar i = 0; i < NUM_OUTPUTS; i++) begin : g_cell
    logic tok_in;
    logic later_in;

    if (i == 0) begin : g_first
      assign tok_in = start;
    end else begin : g_next
      assign tok_in = tok_out_vec[i-1];
    end

    if (i == NUM_OUTPUTS - 1) begin : g_top
      assign later_in = 1'b0;
    end else begin : g_below
      assign later_in = later_vec[i+1];
    end

    if (i < IDX_SPAN) begin : g_addr
      assign set_en_vec[i] = set_acc && (output_index_i == IDX_W'(i));
    end else begin : g_noaddr
      assign set_en_vec[i] = 1'b0;
    end

    tdob_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .tok_i    (tok_in),
      .set_en_i (set_en_vec[i]),
      .level_i  (level_i),
      .count_i  (countdown_i),
      .later_i  (later_in),
      .tok_o    (tok_out_vec[i]),
      .level_o  (lvl_vec[i]),
      .later_o  (later_vec[i]),
      .st_o     (cell_st[i])
    );

    assign tok_vec[i]  = cell_st[i].tok;
    assign fire_vec[i] = cell_st[i].fire;
    assign last_vec[i] = cell_st[i].last;
  end

  // Only one cell holds the token, so plain reductions pick its status.
  assign fire      = |fire_vec;
  assign fire_last = |(fire_vec & last_vec);

  // Level word of the addressable outputs, and the same word with the firing output inverted.
  always_comb begin
    levels_w = '0;
    fire_w   = '0;
    for (int unsigned i = 0; i < LVL_CELLS; i++) begin
      levels_w[i] = lvl_vec[i];
      fire_w[i]   = fire_vec[i];
    end
  end

  assign set_mask   = LVL_W'(1) << output_index_i;
  assign set_levels = (levels_w & ~set_mask) | (level_i ? set_mask : '0);

  // Walk control: the pointer follows the token so the result can name the cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ptr_q  <= '0;
    end else if (start) begin
      busy_q <= 1'b1;
      ptr_q  <= '0;
    end else if (busy_q && adv) begin
      if (ptr_q == PTR_LAST) begin
        busy_q <= 1'b0;
        ptr_q  <= '0;
      end else begin
        ptr_q <= ptr_q + PTR_W'(1);
      end
    end
  end

  // Result register: loaded by a set transfer or by a firing cell, freed by an output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (set_acc || (busy_q && adv && fire)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_acc) begin
      levels_q        <= set_levels;
      changed_index_q <= output_index_i;
      cause_q         <= CAUSE_SET;
      last_q          <= 1'b1;
    end else if (busy_q && adv && fire) begin
      levels_q        <= levels_w ^ fire_w;
      changed_index_q <= IDX_W'(ptr_q);
      cause_q         <= CAUSE_EXPIRY;
      last_q          <= fire_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign levels_o        = levels_q;
  assign changed_index_o = changed_index_q;
  assign cause_o         = cause_q;
  assign last_o          = last_q;

  // The token exists exactly while a walk runs, and never in two cells.
  `TDOB_ASSERT(a_tok_onehot, $onehot0(tok_vec), "more than one cell holds the token")
  `TDOB_ASSERT(a_tok_busy, busy_q == (|tok_vec), "token presence disagrees with the walk flag")
  // A walk ends only after the pointer has reached the last cell.
  `TDOB_ASSERT(a_walk_end, $fell(busy_q) |-> ($past(ptr_q) == PTR_LAST),
    "walk ended before the last cell")
  // A firing step always leaves a result in the output register.
  `TDOB_ASSERT_NEXT(a_fire_loads, busy_q && adv && fire, out_valid_q && (cause_q == CAUSE_EXPIRY),
    "firing cell did not load a result")

endmodule
